// ----- hdl/lir_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
package lir_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned StepW    = 24;
  localparam int unsigned CountW   = 20;
  localparam int unsigned InIdxW   = 21;
  localparam int unsigned PosW     = 40;
  localparam int unsigned FracW    = 16;
  localparam int unsigned RunCntW  = 7;   // counts 0..64 results per input
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStep  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCount = 8'd1;

  localparam logic [StepW-1:0]  StepReset  = 24'd65536;
  localparam logic [CountW-1:0] CountReset = 20'd1024;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StCheck = 5'b00010,
    StMul   = 5'b00100,
    StCalc  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // latch the accepted sample, clear run count
    logic mul;       // register product, advance position and output index
    logic calc;      // form output value and last flag
    logic finish;    // retire input: shift sample, bump input index
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic more;      // another result is due for the current input
    logic last;      // the pending result closes this input's run
  } status_t;

endpackage

// ----- hdl/lir_ctrl.sv -----
// Controller state machine for the linear interpolation resampler.
`timescale 1ns / 1ps
module lir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lir_pkg::status_t  status_i,
  output lir_pkg::cmd_t     cmd_o
);

  lir_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lir_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == lir_pkg::StIdle);
  assign out_valid_o = (state_q == lir_pkg::StEmit);

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    case (state_q)
      lir_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = lir_pkg::StCheck;
        end
      end
      lir_pkg::StCheck: begin
        if (status_i.more) begin
          state_d = lir_pkg::StMul;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = lir_pkg::StIdle;
        end
      end
      lir_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = lir_pkg::StCalc;
      end
      lir_pkg::StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = lir_pkg::StEmit;
      end
      lir_pkg::StEmit: begin
        if (out_ready_i) begin
          if (status_i.last) begin
            cmd_o.finish = 1'b1;
            state_d      = lir_pkg::StIdle;
          end else begin
            state_d = lir_pkg::StMul;
          end
        end
      end
      default: begin
        state_d = lir_pkg::StIdle;
      end
    endcase
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output requests open together");

  a_last_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.last) |=> in_ready_o)
    else $error("last result did not return to idle");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !status_i.last) |=> (state_q == lir_pkg::StMul))
    else $error("run did not continue after non-last result");

endmodule

// ----- hdl/lir_datapath.sv -----
// Datapath: config registers, position tracking, multiplier and output register.
`timescale 1ns / 1ps
module lir_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lir_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lir_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic signed [lir_pkg::SampleW-1:0]  sample_i,
  input  lir_pkg::cmd_t                       cmd_i,
  output lir_pkg::status_t                    status_o,
  output logic signed [lir_pkg::SampleW-1:0]  value_o,
  output logic                                run_last_o,
  output logic                                final_out_o
);

  localparam int unsigned ProdW = 2 * lir_pkg::FracW;
  localparam int unsigned PosIntW = lir_pkg::PosW - lir_pkg::FracW;

  logic [lir_pkg::StepW-1:0]          step_q;
  logic [lir_pkg::CountW-1:0]         count_q;
  logic signed [lir_pkg::SampleW-1:0] prev_q, cur_q;
  logic [lir_pkg::InIdxW-1:0]         in_idx_q;
  logic [lir_pkg::CountW-1:0]         out_idx_q;
  logic [lir_pkg::PosW-1:0]           pos_q;
  logic [lir_pkg::RunCntW-1:0]        run_cnt_q;
  logic [ProdW-1:0]                   prod_q;
  logic                               neg_q, final_q;
  logic signed [lir_pkg::SampleW-1:0] value_q;
  logic                               last_q, final_out_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= lir_pkg::StepReset;
      count_q <= lir_pkg::CountReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lir_pkg::CfgStep) begin
        step_q <= cfg_data_i[lir_pkg::StepW-1:0];
      end else if (cfg_index_i == lir_pkg::CfgCount) begin
        count_q <= cfg_data_i[lir_pkg::CountW-1:0];
      end
    end
  end

  // Loop condition on current registers
  logic [lir_pkg::InIdxW-1:0] left;
  logic [PosIntW-1:0]         pos_int;
  logic                       more;

  assign left    = in_idx_q - lir_pkg::InIdxW'(1);
  assign pos_int = pos_q[lir_pkg::PosW-1:lir_pkg::FracW];
  assign more    = (in_idx_q != '0) && !run_cnt_q[lir_pkg::RunCntW-1] &&
                   (out_idx_q < count_q) &&
                   (pos_int <= PosIntW'(left));

  assign status_o.more = more;
  assign status_o.last = last_q;

  // Difference magnitude and sign
  logic signed [lir_pkg::SampleW:0] diff;
  logic [lir_pkg::SampleW:0]        mag;
  assign diff = 17'(cur_q) - 17'(prev_q);
  assign mag  = diff[lir_pkg::SampleW] ? 17'(-diff) : 17'(diff);

  // Saturating position advance
  logic [lir_pkg::PosW:0] pos_sum;
  assign pos_sum = {1'b0, pos_q} + (lir_pkg::PosW + 1)'(step_q);

  logic [lir_pkg::CountW:0] out_idx_inc;
  assign out_idx_inc = {1'b0, out_idx_q} + (lir_pkg::CountW + 1)'(1);

  // Interpolated value from registered product
  logic [lir_pkg::SampleW-1:0] q;
  logic [lir_pkg::SampleW:0]   val_wide;
  assign q        = prod_q[ProdW-1:lir_pkg::FracW];
  assign val_wide = neg_q ? (17'(prev_q) - {1'b0, q}) : (17'(prev_q) + {1'b0, q});

  // Stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      in_idx_q  <= '0;
      out_idx_q <= '0;
      pos_q     <= '0;
      run_cnt_q <= '0;
      last_q    <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        run_cnt_q <= '0;
      end
      if (cmd_i.mul) begin
        out_idx_q <= out_idx_inc[lir_pkg::CountW-1:0];
        run_cnt_q <= run_cnt_q + lir_pkg::RunCntW'(1);
        pos_q     <= pos_sum[lir_pkg::PosW] ? '1 : pos_sum[lir_pkg::PosW-1:0];
      end
      if (cmd_i.calc) begin
        last_q <= !more;
      end
      if (cmd_i.finish) begin
        prev_q <= cur_q;
        if (in_idx_q != '1) begin
          in_idx_q <= in_idx_q + lir_pkg::InIdxW'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q <= sample_i;
    end
    if (cmd_i.mul) begin
      prod_q  <= mag[lir_pkg::SampleW-1:0] * pos_q[lir_pkg::FracW-1:0];
      neg_q   <= diff[lir_pkg::SampleW];
      final_q <= (out_idx_inc == {1'b0, count_q});
    end
    if (cmd_i.calc) begin
      value_q     <= val_wide[lir_pkg::SampleW-1:0];
      final_out_q <= final_q;
    end
  end

  assign value_o     = value_q;
  assign run_last_o  = last_q;
  assign final_out_o = final_out_q;

endmodule

// ----- hdl/linear_interp_resampler_top.sv -----
// Sequence: an accepted input is checked, then its first result is multiplied, formed and
// presented; each further result of the same input is again multiplied, formed and presented.
// An input that causes no result is retired from the check state; one input is in work at a time.
// The multiply-then-form sequence over one shared 16x16 multiplier sets the rate, with receiver stalls.
// Reset (async, active low) clears stream state; step = 1.0, count = 1024.
`timescale 1ns / 1ps
module linear_interp_resampler_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lir_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lir_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lir_pkg::SampleW-1:0]  sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lir_pkg::SampleW-1:0]  value_o,
  output logic                                run_last_o,
  output logic                                final_out_o
);

  lir_pkg::cmd_t    cmd;
  lir_pkg::status_t status;

  // Config requests always taken
  assign cfg_ready_o = 1'b1;

  lir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lir_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_o     (value_o),
    .run_last_o  (run_last_o),
    .final_out_o (final_out_o)
  );

endmodule

// ----- test/lir_resample_monitor.sv -----
// Stream monitor for the resampler: predicts interpolated results and checks them.
`timescale 1ns / 1ps
module lir_resample_monitor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [lir_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lir_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [lir_pkg::SampleW-1:0] sample_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [lir_pkg::SampleW-1:0] value_i,
  input  logic                               run_last_i,
  input  logic                               final_out_i,
  output int                                 pending_o,
  output logic [lir_pkg::CountW-1:0]         issued_o,
  output int                                 errors_o
);

  localparam int                         MaxRun = 64;
  localparam logic [lir_pkg::PosW-1:0]   PosMax = '1;
  localparam logic [lir_pkg::InIdxW-1:0] InMax  = '1;

  typedef struct packed {
    logic [lir_pkg::SampleW-1:0] value;
    logic                        run_last;
    logic                        final_out;
  } interp_res_t;

  // Shadow of the block's settings and stream state
  logic [lir_pkg::StepW-1:0]          step_q16;
  logic [lir_pkg::CountW-1:0]         out_total;
  logic signed [lir_pkg::SampleW-1:0] left_sample;
  logic [lir_pkg::InIdxW-1:0]         samples_seen;
  logic [lir_pkg::CountW-1:0]         outs_done;
  logic [lir_pkg::PosW-1:0]           pos_q16;

  interp_res_t due_outputs[$];
  int          errors;

  assign errors_o = errors;

  // Expected results for one accepted sample, queued in emission order
  task automatic interpolate_run(input logic signed [lir_pkg::SampleW-1:0] cur);
    logic [lir_pkg::InIdxW-1:0] left_idx;
    int                         n;
    int                         diff;
    int                         mag;
    logic [31:0]                prod;
    int                         v;
    interp_res_t                held;
    n = 0;
    held = '0;
    if (samples_seen != '0) begin
      left_idx = samples_seen - 1'b1;
      while (n < MaxRun && outs_done < out_total &&
             pos_q16[lir_pkg::PosW-1:lir_pkg::FracW] <= {3'b000, left_idx}) begin
        diff = int'(cur) - int'(left_sample);
        mag  = (diff < 0) ? -diff : diff;
        prod = mag * pos_q16[lir_pkg::FracW-1:0];
        prod = prod >> lir_pkg::FracW;
        v = (diff < 0) ? int'(left_sample) - int'(prod) : int'(left_sample) + int'(prod);
        if (n > 0) due_outputs.insert(due_outputs.size(), held);
        held.value     = v[lir_pkg::SampleW-1:0];
        held.run_last  = 1'b0;
        held.final_out = ((outs_done + 20'd1) == out_total);
        outs_done++;
        // saturating position advance
        if (PosMax - pos_q16 < {16'd0, step_q16}) pos_q16 = PosMax;
        else pos_q16 = pos_q16 + {16'd0, step_q16};
        n++;
      end
      if (n > 0) begin
        held.run_last = 1'b1;
        due_outputs.insert(due_outputs.size(), held);
      end
    end
    left_sample = cur;
    if (samples_seen != InMax) samples_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    interp_res_t want;
    if (!rst_ni) begin
      step_q16     = lir_pkg::StepReset;
      out_total    = lir_pkg::CountReset;
      left_sample  = '0;
      samples_seen = '0;
      outs_done    = '0;
      pos_q16      = '0;
      due_outputs.delete();
      errors       = 0;
      pending_o   <= 0;
      issued_o    <= '0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == lir_pkg::CfgStep) begin
          step_q16 = cfg_data_i[lir_pkg::StepW-1:0];
        end else if (cfg_index_i == lir_pkg::CfgCount) begin
          out_total = cfg_data_i[lir_pkg::CountW-1:0];
        end
      end
      if (in_valid_i && in_ready_i) interpolate_run(sample_i);
      // compare each result with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (due_outputs.size() == 0) begin
          $display("%0t: unexpected result value %0d run_last %0b final_out %0b",
                   $time, value_i, run_last_i, final_out_i);
          errors++;
        end else begin
          want = due_outputs.pop_front();
          if (value_i !== want.value) begin
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, $signed(want.value), value_i);
            errors++;
          end
          if (run_last_i !== want.run_last) begin
            $display("%0t: run_last mismatch, expected %0b actual %0b",
                     $time, want.run_last, run_last_i);
            errors++;
          end
          if (final_out_i !== want.final_out) begin
            $display("%0t: final_out mismatch, expected %0b actual %0b",
                     $time, want.final_out, final_out_i);
            errors++;
          end
        end
      end
      pending_o <= due_outputs.size();
      issued_o  <= outs_done;
    end
  end

endmodule

// ----- test/linear_interp_resampler_top_test.sv -----
// Testbench top for the resampler: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module linear_interp_resampler_top_test;

  localparam int                          SettleCycles = 8;
  localparam int                          LongHold     = 400;
  localparam int                          RandPhases   = 7;
  localparam int                          PhaseItems   = 10;
  localparam int                          TailItems    = 20;
  localparam logic [lir_pkg::CfgIdxW-1:0] CfgNone      = 8'hFF;
  localparam logic [lir_pkg::CfgIdxW-1:0] CfgSpare     = 8'h02;
  localparam logic [lir_pkg::CountW-1:0]  CountMax     = '1;
  localparam logic [lir_pkg::StepW-1:0]   StepMax      = '1;
  localparam logic [lir_pkg::StepW-1:0]   StepMin      = 24'd1024;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [lir_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [lir_pkg::CfgDataW-1:0]       cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [lir_pkg::SampleW-1:0] sample_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [lir_pkg::SampleW-1:0] value_o;
  logic                               run_last_o;
  logic                               final_out_o;

  int                                 pending;
  logic [lir_pkg::CountW-1:0]         issued;
  int                                 fail_count;

  // receiver control, set by the stimulus process
  bit                                 hold_off_req = 1'b0;
  bit                                 sink_steady  = 1'b0;
  int                                 stall_left   = 0;

  always begin
    #6 clk_i = ~clk_i;
  end

  linear_interp_resampler_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .run_last_o  (run_last_o),
    .final_out_o (final_out_o)
  );

  lir_resample_monitor monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_i     (value_o),
    .run_last_i  (run_last_o),
    .final_out_i (final_out_o),
    .pending_o   (pending),
    .issued_o    (issued),
    .errors_o    (fail_count)
  );

  // Idle lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 96) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [lir_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return lir_pkg::SampleW'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until taken; valid stays up when no gap follows
  task automatic send_sample(input logic signed [lir_pkg::SampleW-1:0] smp, input int gap);
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One register write request; the caller drops valid after the last one
  task automatic write_reg(input logic [lir_pkg::CfgIdxW-1:0] idx,
                           input logic [lir_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_rates(input logic [lir_pkg::StepW-1:0] step,
                           input logic [lir_pkg::CountW-1:0] total);
    write_reg(lir_pkg::CfgStep, step);
    write_reg(lir_pkg::CfgCount, {4'h0, total});
  endtask

  // Sample valid must already be low; wait out every expected result plus retire time
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off on request, steady stretches
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LongHold;
      end else if (!sink_steady && stall_left == 0 && $urandom_range(9) < 3) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic signed [lir_pkg::SampleW-1:0] extremes [6];
    logic [lir_pkg::StepW-1:0]          step_pick;
    logic [lir_pkg::CountW-1:0]         count_pick;
    int                                 gap_mode;
    extremes = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, step 1.0: first sample only stored, then full-scale swings
    foreach (extremes[i]) send_sample(extremes[i], gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Minimum step: 64 results per sample, run ends with a final flag
    set_rates(StepMin, issued + 20'd100);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh8000, gap_len());
    send_sample(16'sh7FFF, gap_len());
    send_sample(16'sh0001, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Count of zero through masked upper bits, then a count below what was produced
    write_reg(lir_pkg::CfgCount, 24'hF00000);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh1234, gap_len());
    send_sample(16'shEDCB, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(lir_pkg::CfgCount, 24'd1);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh4000, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Zero step: position holds, 64 results per sample until the count runs out
    set_rates('0, issued + 20'd70);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh7FFF, gap_len());
    send_sample(16'sh8000, gap_len());
    send_sample(16'sh0100, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Tiny step with a lagging position; writes to unknown indexes must be dropped
    set_rates(24'd1, issued + 20'd150);
    write_reg(CfgNone, 24'hFFFFFF);
    write_reg(CfgSpare, 24'h000000);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh8000, gap_len());
    send_sample(16'sh7FFF, gap_len());
    send_sample(16'shC000, gap_len());
    send_sample(16'sh3FFF, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Largest count with a fractional step
    set_rates(24'h018000, CountMax);
    cfg_valid_i <= 1'b0;
    send_sample(16'sh7FFF, gap_len());
    send_sample(16'sh8000, gap_len());
    send_sample(16'sh0000, gap_len());
    in_valid_i <= 1'b0;
    wait_drained();

    // Random phases: mixed rates, bounded counts but one at the maximum, one phase with a long receiver stall
    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(3))
        0:       step_pick = lir_pkg::StepW'($urandom_range(24'h4000, StepMin));
        1:       step_pick = 24'h010000;
        2:       step_pick = lir_pkg::StepW'($urandom_range(24'h40000, 24'h4000));
        default: step_pick = lir_pkg::StepW'($urandom_range(24'h80000, 24'h1));
      endcase
      count_pick = issued + lir_pkg::CountW'($urandom_range(300, 20));
      if (ph == 3) count_pick = CountMax;
      if (ph == 0) step_pick = 24'd2048;
      set_rates(step_pick, count_pick);
      cfg_valid_i <= 1'b0;
      gap_mode    = ph % 3;
      sink_steady = (gap_mode == 1);
      // block fills and stalls its input while the receiver holds off
      if (ph == 0) hold_off_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        send_sample(pick_sample(), (gap_mode == 0) ? gap_len() : 0);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end
    sink_steady = 1'b0;

    // Largest step: outputs spaced about 256 samples apart
    set_rates(StepMax, issued + 20'd2);
    cfg_valid_i <= 1'b0;
    for (int k = 0; k < TailItems; k++) send_sample(pick_sample(), 0);
    in_valid_i <= 1'b0;
    wait_drained();

    if (fail_count == 0) begin
      $display("linear_interp_resampler_top_test: PASS");
    end else begin
      $display("linear_interp_resampler_top_test: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(64'd40_000_000);
    $display("linear_interp_resampler_top_test: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lir_pkg.sv
hdl/lir_ctrl.sv
hdl/lir_datapath.sv
hdl/linear_interp_resampler_top.sv
test/lir_resample_monitor.sv
test/linear_interp_resampler_top_test.sv
